FILE: sv/bfd_pkg.sv
package bfd_pkg;

  localparam int DEF_MAX_DST = 256;
  localparam int DEF_MAX_SRC = 4096;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 13;
  localparam int DSIZE_W = 9;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_DST_SIZE   = 2'd2;

  localparam logic [CFG_W-1:0]   RST_SRC_WIDTH  = 13'd2048;
  localparam logic [CFG_W-1:0]   RST_SRC_HEIGHT = 13'd2048;
  localparam logic [DSIZE_W-1:0] RST_DST_SIZE   = 9'd256;

  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [2:0] {
    DIV_W,
    DIV_H,
    DIV_R,
    DIV_G,
    DIV_B
  } div_sel_t;

  typedef enum logic [3:0] {
    C_CLR,
    C_DW,
    C_WW,
    C_DH,
    C_WH,
    C_INIT,
    C_IDLE,
    C_RD,
    C_ACC,
    C_DR,
    C_WR,
    C_DG,
    C_WG,
    C_DB,
    C_WB,
    C_LD
  } ctl_state_t;

  typedef struct packed {
    logic     take;
    logic     rd;
    logic     acc;
    logic     clr_step;
    logic     frame_init;
    logic     div_start;
    div_sel_t div_sel;
    logic     load_out;
  } bfd_cmd_t;

  typedef struct packed {
    logic restart;
    logic clr_last;
    logic div_done;
    logic texel;
    logic out_free;
  } bfd_sts_t;

endpackage

FILE: sv/box_filter_image_downscale.sv
// Area-average downscaler: source RGB pixels in raster order become a square
// dst_size x dst_size image; each texel is the truncated mean of its footprint
// and leaves with alpha 255 on the pixel that completes it. A pixel that does
// not complete a texel is accepted, its sum memory entry read, then accumulated.
// A completing pixel adds three passes of the shared bit-serial divider and a
// load of the output register, which waits while the output is stalled. After
// reset and after every write to a defined configuration register the block
// clears all MAX_DST entries of its column sum memories, then spends two divider
// passes on the footprint steps and a frame init step before accepting pixels.
module box_filter_image_downscale #(
  parameter int MAX_DST = bfd_pkg::DEF_MAX_DST,
  parameter int MAX_SRC = bfd_pkg::DEF_MAX_SRC
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bfd_pkg::PIX_W-1:0]    in_pix_red,
  input  logic [bfd_pkg::PIX_W-1:0]    in_pix_green,
  input  logic [bfd_pkg::PIX_W-1:0]    in_pix_blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bfd_pkg::PIX_W-1:0]    out_red,
  output logic [bfd_pkg::PIX_W-1:0]    out_green,
  output logic [bfd_pkg::PIX_W-1:0]    out_blue,
  output logic [bfd_pkg::PIX_W-1:0]    out_alpha,
  output logic [7:0]                   out_col,
  output logic [7:0]                   out_row,
  output logic                         out_frame_end
);
  import bfd_pkg::*;

  bfd_cmd_t cmd;
  bfd_sts_t sts;

  assign cfg_ready = 1'b1;
  assign in_stall  = !cmd.take;

  bfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfd_dp #(
    .MAX_DST (MAX_DST),
    .MAX_SRC (MAX_SRC)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_pix_red    (in_pix_red),
    .in_pix_green  (in_pix_green),
    .in_pix_blue   (in_pix_blue),
    .in_valid      (in_valid),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_frame_end (out_frame_end)
  );

endmodule

FILE: sv/bfd_ctrl.sv
module bfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  bfd_pkg::bfd_sts_t sts,
  output bfd_pkg::bfd_cmd_t cmd
);
  import bfd_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.div_sel = DIV_W;
    state_nxt = state_r;
    case (state_r)
      C_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = C_DW;
      end
      C_DW: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_W;
        state_nxt     = C_WW;
      end
      C_WW: if (sts.div_done) state_nxt = C_DH;
      C_DH: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_H;
        state_nxt     = C_WH;
      end
      C_WH: if (sts.div_done) state_nxt = C_INIT;
      C_INIT: begin
        cmd.frame_init = 1'b1;
        state_nxt      = C_IDLE;
      end
      C_IDLE: begin
        cmd.take = 1'b1;
        if (in_valid) state_nxt = C_RD;
      end
      C_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = C_ACC;
      end
      C_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.texel ? C_DR : C_IDLE;
      end
      C_DR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_R;
        state_nxt     = C_WR;
      end
      C_WR: if (sts.div_done) state_nxt = C_DG;
      C_DG: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_G;
        state_nxt     = C_WG;
      end
      C_WG: if (sts.div_done) state_nxt = C_DB;
      C_DB: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_B;
        state_nxt     = C_WB;
      end
      C_WB: if (sts.div_done) state_nxt = C_LD;
      C_LD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = C_IDLE;
        end
      end
      default: state_nxt = C_CLR;
    endcase
    if (sts.restart) state_nxt = C_CLR;
  end

endmodule

FILE: sv/bfd_dp.sv
module bfd_dp #(
  parameter int MAX_DST = bfd_pkg::DEF_MAX_DST,
  parameter int MAX_SRC = bfd_pkg::DEF_MAX_SRC
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [bfd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]    cfg_data,
  input  logic [bfd_pkg::PIX_W-1:0]    in_pix_red,
  input  logic [bfd_pkg::PIX_W-1:0]    in_pix_green,
  input  logic [bfd_pkg::PIX_W-1:0]    in_pix_blue,
  input  logic                         in_valid,
  input  bfd_pkg::bfd_cmd_t            cmd,
  output bfd_pkg::bfd_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bfd_pkg::PIX_W-1:0]    out_red,
  output logic [bfd_pkg::PIX_W-1:0]    out_green,
  output logic [bfd_pkg::PIX_W-1:0]    out_blue,
  output logic [bfd_pkg::PIX_W-1:0]    out_alpha,
  output logic [7:0]                   out_col,
  output logic [7:0]                   out_row,
  output logic                         out_frame_end
);
  import bfd_pkg::*;

  localparam int CW    = $clog2(MAX_SRC + 1);
  localparam int SW    = $clog2(MAX_DST + 1);
  localparam int XW    = $clog2(MAX_DST);
  localparam int AW    = 2 * CW;
  localparam int SUM_W = PIX_W + AW;
  localparam int NW    = $clog2(SUM_W + 1);

  // configuration
  logic [CFG_W-1:0]   src_width_r, src_height_r;
  logic [DSIZE_W-1:0] dst_size_r;
  logic               restart;

  assign restart = cfg_valid && (cfg_index == REG_SRC_WIDTH ||
                   cfg_index == REG_SRC_HEIGHT || cfg_index == REG_DST_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_WIDTH;
      src_height_r <= RST_SRC_HEIGHT;
      dst_size_r   <= RST_DST_SIZE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        REG_SRC_HEIGHT: src_height_r <= cfg_data;
        REG_DST_SIZE:   dst_size_r   <= cfg_data[DSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [CW-1:0] w_eff, h_eff;
  logic [SW-1:0] s_eff;
  logic [31:0]   s_c;

  always_comb begin
    if (src_width_r == '0) w_eff = CW'(1);
    else if (32'(src_width_r) > 32'(MAX_SRC)) w_eff = CW'(MAX_SRC);
    else w_eff = CW'(src_width_r);
    if (src_height_r == '0) h_eff = CW'(1);
    else if (32'(src_height_r) > 32'(MAX_SRC)) h_eff = CW'(MAX_SRC);
    else h_eff = CW'(src_height_r);
    if (dst_size_r == '0) s_c = 32'd1;
    else if (32'(dst_size_r) > 32'(MAX_DST)) s_c = 32'(MAX_DST);
    else s_c = 32'(dst_size_r);
    if (s_c > 32'(w_eff)) s_c = 32'(w_eff);
    if (s_c > 32'(h_eff)) s_c = 32'(h_eff);
    s_eff = SW'(s_c);
  end

  // shared restoring divider
  logic [SUM_W-1:0] dv_num_r;
  logic [AW-1:0]    dv_rem_r, dv_den_r, dv_rem_nxt;
  logic [NW-1:0]    dv_cnt_r;
  logic             dv_busy_r, dv_done_r;
  div_sel_t         dv_sel_r;
  logic [AW:0]      dv_sh, dv_diff;
  logic             dv_ge;

  logic [CW-1:0]    q_w_r, q_h_r;
  logic [SW-1:0]    r_w_r, r_h_r;
  logic [PIX_W-1:0] q_red_r, q_green_r, q_blue_r;
  logic [SUM_W-1:0] tex_red_r, tex_green_r, tex_blue_r;
  logic [AW-1:0]    area_r;

  assign dv_sh      = {dv_rem_r, dv_num_r[SUM_W-1]};
  assign dv_diff    = dv_sh - {1'b0, dv_den_r};
  assign dv_ge      = dv_sh >= {1'b0, dv_den_r};
  assign dv_rem_nxt = dv_ge ? dv_diff[AW-1:0] : dv_sh[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_done_r <= 1'b0;
      dv_cnt_r  <= '0;
    end else begin
      dv_done_r <= 1'b0;
      if (cmd.div_start) begin
        dv_busy_r <= 1'b1;
        dv_cnt_r  <= NW'(SUM_W);
      end else if (dv_busy_r) begin
        dv_cnt_r <= dv_cnt_r - NW'(1);
        if (dv_cnt_r == NW'(1)) begin
          dv_busy_r <= 1'b0;
          dv_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_sel_r <= cmd.div_sel;
      dv_rem_r <= '0;
      case (cmd.div_sel)
        DIV_W: begin
          dv_num_r <= SUM_W'(w_eff);
          dv_den_r <= AW'(s_eff);
        end
        DIV_H: begin
          dv_num_r <= SUM_W'(h_eff);
          dv_den_r <= AW'(s_eff);
        end
        DIV_R: begin
          dv_num_r <= tex_red_r;
          dv_den_r <= area_r;
        end
        DIV_G: begin
          dv_num_r <= tex_green_r;
          dv_den_r <= area_r;
        end
        DIV_B: begin
          dv_num_r <= tex_blue_r;
          dv_den_r <= area_r;
        end
        default: begin
          dv_num_r <= '0;
          dv_den_r <= AW'(1);
        end
      endcase
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_rem_nxt;
      dv_num_r <= {dv_num_r[SUM_W-2:0], dv_ge};
    end
    if (dv_done_r) begin
      case (dv_sel_r)
        DIV_W: begin
          q_w_r <= CW'(dv_num_r);
          r_w_r <= SW'(dv_rem_r);
        end
        DIV_H: begin
          q_h_r <= CW'(dv_num_r);
          r_h_r <= SW'(dv_rem_r);
        end
        DIV_R:   q_red_r   <= dv_num_r[PIX_W-1:0];
        DIV_G:   q_green_r <= dv_num_r[PIX_W-1:0];
        DIV_B:   q_blue_r  <= dv_num_r[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // position and footprint tracking
  logic [CW-1:0] src_col_r, src_row_r;
  logic [XW-1:0] cx_r, cy_r;
  logic [CW-1:0] col_start_r, col_edge_r, row_start_r, row_edge_r;
  logic [SW-1:0] col_rem_r, row_rem_r;
  logic [SW:0]   col_rs, row_rs;
  logic          col_cy, row_cy;
  logic          col_end, row_end, col_last, row_last, texel, fend;
  logic [CW-1:0] cw_len, rh_len;

  assign col_rs   = {1'b0, col_rem_r} + {1'b0, r_w_r};
  assign row_rs   = {1'b0, row_rem_r} + {1'b0, r_h_r};
  assign col_cy   = col_rs >= {1'b0, s_eff};
  assign row_cy   = row_rs >= {1'b0, s_eff};
  assign col_end  = (src_col_r + CW'(1)) == col_edge_r;
  assign row_end  = (src_row_r + CW'(1)) == row_edge_r;
  assign col_last = src_col_r == (w_eff - CW'(1));
  assign row_last = src_row_r == (h_eff - CW'(1));
  assign texel    = col_end && row_end;
  assign fend     = (SW'(cx_r) == s_eff - SW'(1)) && (SW'(cy_r) == s_eff - SW'(1));
  assign cw_len   = col_edge_r - col_start_r;
  assign rh_len   = row_edge_r - row_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r   <= '0;
      src_row_r   <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      col_start_r <= '0;
      col_edge_r  <= '0;
      col_rem_r   <= '0;
      row_start_r <= '0;
      row_edge_r  <= '0;
      row_rem_r   <= '0;
    end else if (cmd.frame_init) begin
      src_col_r   <= '0;
      src_row_r   <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      col_start_r <= '0;
      col_edge_r  <= q_w_r;
      col_rem_r   <= r_w_r;
      row_start_r <= '0;
      row_edge_r  <= q_h_r;
      row_rem_r   <= r_h_r;
    end else if (cmd.acc) begin
      if (col_last) begin
        src_col_r   <= '0;
        cx_r        <= '0;
        col_start_r <= '0;
        col_edge_r  <= q_w_r;
        col_rem_r   <= r_w_r;
        if (row_last) begin
          src_row_r   <= '0;
          cy_r        <= '0;
          row_start_r <= '0;
          row_edge_r  <= q_h_r;
          row_rem_r   <= r_h_r;
        end else begin
          src_row_r <= src_row_r + CW'(1);
          if (row_end) begin
            cy_r        <= cy_r + XW'(1);
            row_start_r <= row_edge_r;
            row_edge_r  <= row_edge_r + q_h_r + CW'(row_cy);
            row_rem_r   <= row_cy ? SW'(row_rs - {1'b0, s_eff}) : SW'(row_rs);
          end
        end
      end else begin
        src_col_r <= src_col_r + CW'(1);
        if (col_end) begin
          cx_r        <= cx_r + XW'(1);
          col_start_r <= col_edge_r;
          col_edge_r  <= col_edge_r + q_w_r + CW'(col_cy);
          col_rem_r   <= col_cy ? SW'(col_rs - {1'b0, s_eff}) : SW'(col_rs);
        end
      end
    end
  end

  // column sum memories
  logic [SUM_W-1:0] mem_red   [MAX_DST];
  logic [SUM_W-1:0] mem_green [MAX_DST];
  logic [SUM_W-1:0] mem_blue  [MAX_DST];
  logic [SUM_W-1:0] rd_red_r, rd_green_r, rd_blue_r;
  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;
  logic [PIX_W-1:0] pix_red_r, pix_green_r, pix_blue_r;
  logic [XW-1:0]    clr_addr_r, wr_addr;
  logic             clr_last, mem_we;
  logic [SUM_W-1:0] wr_red, wr_green, wr_blue;
  logic [7:0]       tex_col_r, tex_row_r;
  logic             tex_fend_r;

  assign clr_last  = clr_addr_r == XW'(MAX_DST - 1);
  assign sum_red   = rd_red_r + SUM_W'(pix_red_r);
  assign sum_green = rd_green_r + SUM_W'(pix_green_r);
  assign sum_blue  = rd_blue_r + SUM_W'(pix_blue_r);
  assign mem_we    = cmd.clr_step || cmd.acc;
  assign wr_addr   = cmd.clr_step ? clr_addr_r : cx_r;
  assign wr_red    = (cmd.clr_step || texel) ? '0 : sum_red;
  assign wr_green  = (cmd.clr_step || texel) ? '0 : sum_green;
  assign wr_blue   = (cmd.clr_step || texel) ? '0 : sum_blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (restart) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + XW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_red[wr_addr]   <= wr_red;
      mem_green[wr_addr] <= wr_green;
      mem_blue[wr_addr]  <= wr_blue;
    end
    if (cmd.rd) begin
      rd_red_r   <= mem_red[cx_r];
      rd_green_r <= mem_green[cx_r];
      rd_blue_r  <= mem_blue[cx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_valid) begin
      pix_red_r   <= in_pix_red;
      pix_green_r <= in_pix_green;
      pix_blue_r  <= in_pix_blue;
    end
    if (cmd.acc && texel) begin
      tex_red_r   <= sum_red;
      tex_green_r <= sum_green;
      tex_blue_r  <= sum_blue;
      area_r      <= AW'(cw_len) * AW'(rh_len);
      tex_col_r   <= 8'(cx_r);
      tex_row_r   <= 8'(cy_r);
      tex_fend_r  <= fend;
    end
  end

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [7:0]       out_col_r, out_row_r;
  logic             out_fend_r;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_red_r   <= q_red_r;
      out_green_r <= q_green_r;
      out_blue_r  <= q_blue_r;
      out_col_r   <= tex_col_r;
      out_row_r   <= tex_row_r;
      out_fend_r  <= tex_fend_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_alpha     = ALPHA_OPAQUE;
  assign out_col       = out_col_r;
  assign out_row       = out_row_r;
  assign out_frame_end = out_fend_r;

  assign sts.restart  = restart;
  assign sts.clr_last = clr_last;
  assign sts.div_done = dv_done_r;
  assign sts.texel    = texel;
  assign sts.out_free = out_free;

`ifndef SYNTHESIS
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !dv_busy_r)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done_r |=> !dv_done_r)
    else $error("divider done held");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("output overwritten");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import bfd_pkg::*;

  localparam int                NUM_COLS    = DEF_MAX_DST;
  localparam int                SRC_LIMIT   = DEF_MAX_SRC;
  localparam logic [IDX_W-1:0]  REG_UNUSED  = 2'd3;
  localparam int                SETTLE_CYC  = 150;
  localparam int                TAIL_CYC    = 400;
  localparam int                HOLD_CYC    = 2000;
  localparam int                STUCK_LIMIT = 20000;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic [7:0]       col;
    logic [7:0]       row;
    logic             last;
  } texel_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_pix_red = '0;
  logic [PIX_W-1:0]   in_pix_green = '0;
  logic [PIX_W-1:0]   in_pix_blue = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   out_red;
  logic [PIX_W-1:0]   out_green;
  logic [PIX_W-1:0]   out_blue;
  logic [PIX_W-1:0]   out_alpha;
  logic [7:0]         out_col;
  logic [7:0]         out_row;
  logic               out_frame_end;

  box_filter_image_downscale u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pix_red   (in_pix_red),
    .in_pix_green (in_pix_green),
    .in_pix_blue  (in_pix_blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_frame_end(out_frame_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // downscaler state mirror
  logic [CFG_W-1:0]   reg_w = RST_SRC_WIDTH;
  logic [CFG_W-1:0]   reg_h = RST_SRC_HEIGHT;
  logic [DSIZE_W-1:0] reg_s = RST_DST_SIZE;
  longint unsigned    sum_r [NUM_COLS];
  longint unsigned    sum_g [NUM_COLS];
  longint unsigned    sum_b [NUM_COLS];
  int unsigned        src_col, src_row, tex_col, tex_row, col_end, row_end;
  texel_t             texels_due[$];

  int   errors = 0;
  int   burst_left = 0;
  bit   gapless = 1'b0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   stall_mode = 0;
  int   stuck = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned width_eff();
    return clampu(reg_w, SRC_LIMIT);
  endfunction

  function automatic int unsigned height_eff();
    return clampu(reg_h, SRC_LIMIT);
  endfunction

  function automatic int unsigned size_eff();
    int unsigned s;
    s = clampu(reg_s, NUM_COLS);
    if (s > width_eff()) s = width_eff();
    if (s > height_eff()) s = height_eff();
    return s;
  endfunction

  function automatic int unsigned span_end(int unsigned i, int unsigned src, int unsigned s);
    return int'((longint'(i) * longint'(src)) / longint'(s));
  endfunction

  function automatic void frame_restart();
    for (int i = 0; i < NUM_COLS; i++) begin
      sum_r[i] = 0;
      sum_g[i] = 0;
      sum_b[i] = 0;
    end
    src_col = 0;
    src_row = 0;
    tex_col = 0;
    tex_row = 0;
    col_end = span_end(1, width_eff(), size_eff());
    row_end = span_end(1, height_eff(), size_eff());
  endfunction

  function automatic void reg_update(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_SRC_WIDTH: reg_w = val;
      REG_SRC_HEIGHT: reg_h = val;
      REG_DST_SIZE: reg_s = val[DSIZE_W-1:0];
      default: return;
    endcase
    frame_restart();
  endfunction

  function automatic void pixel_absorb(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                       logic [PIX_W-1:0] b);
    int unsigned     w, h, s, cx;
    longint unsigned area;
    texel_t          t;
    w = width_eff();
    h = height_eff();
    s = size_eff();
    cx = tex_col;
    if (cx >= s || src_col >= w || src_row >= h) begin
      frame_restart();
      cx = 0;
    end
    sum_r[cx] += r;
    sum_g[cx] += g;
    sum_b[cx] += b;
    if (src_col + 1 == col_end) begin
      if (src_row + 1 == row_end) begin
        area = longint'(col_end - span_end(cx, w, s)) *
               longint'(row_end - span_end(tex_row, h, s));
        if (area == 0) area = 1;
        t.red   = 8'(sum_r[cx] / area);
        t.green = 8'(sum_g[cx] / area);
        t.blue  = 8'(sum_b[cx] / area);
        t.alpha = ALPHA_OPAQUE;
        t.col   = 8'(cx);
        t.row   = 8'(tex_row);
        t.last  = (cx + 1 == s) && (tex_row + 1 == s);
        texels_due = {texels_due, t};
        sum_r[cx] = 0;
        sum_g[cx] = 0;
        sum_b[cx] = 0;
      end
      cx++;
      tex_col = cx;
      if (cx < s) col_end = span_end(cx + 1, w, s);
    end
    src_col++;
    if (src_col >= w) begin
      src_col = 0;
      tex_col = 0;
      col_end = span_end(1, w, s);
      if (src_row + 1 == row_end) begin
        tex_row++;
        if (tex_row < s) row_end = span_end(tex_row + 1, h, s);
      end
      src_row++;
      if (src_row >= h) begin
        src_row = 0;
        tex_row = 0;
        row_end = span_end(1, h, s);
      end
    end
  endfunction

  // result side stall pattern, with a one-shot long hold
  always @(posedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYC;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        2: out_stall <= ($urandom_range(1) == 0);
        default: out_stall <= ($urandom_range(7) != 0);
      endcase
    end
    if ($urandom_range(63) == 0) stall_mode <= $urandom_range(3);
  end

  always @(posedge clk) begin
    texel_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (texels_due.size() == 0) begin
        $display("%0t: unexpected texel col %0d row %0d", $time, out_col, out_row);
        errors++;
      end else begin
        t = texels_due.pop_front();
        if (out_red !== t.red || out_green !== t.green || out_blue !== t.blue ||
            out_alpha !== t.alpha || out_col !== t.col || out_row !== t.row ||
            out_frame_end !== t.last) begin
          $display("%0t: expected rgba %0d %0d %0d %0d col %0d row %0d end %0d", $time,
                   t.red, t.green, t.blue, t.alpha, t.col, t.row, t.last);
          $display("%0t: actual   rgba %0d %0d %0d %0d col %0d row %0d end %0d", $time,
                   out_red, out_green, out_blue, out_alpha, out_col, out_row,
                   out_frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                            logic [PIX_W-1:0] b, bit more);
    in_valid     <= 1'b1;
    in_pix_red   <= r;
    in_pix_green <= g;
    in_pix_blue  <= b;
    do @(posedge clk); while (in_stall);
    pixel_absorb(r, g, b);
    if (burst_left > 0) burst_left--;
    if (!more) begin
      in_valid <= 1'b0;
    end else if (burst_left == 0 && !gapless) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: send_pixel(8'd0, 8'd0, 8'd0, i != n - 1);
        1: send_pixel(8'd255, 8'd255, 8'd255, i != n - 1);
        default: send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                            i != n - 1);
      endcase
    end
  endtask

  task automatic drain();
    while (texels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_update(idx, val);
  endtask

  task automatic set_geometry(int w, int h, int s);
    write_reg(REG_SRC_WIDTH, CFG_W'(w));
    write_reg(REG_SRC_HEIGHT, CFG_W'(h));
    write_reg(REG_DST_SIZE, CFG_W'(s));
  endtask

  task automatic test_extremes();
    set_geometry(2, 2, 1);
    repeat (4) send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    repeat (4) send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd128, 1'b0);
  endtask

  task automatic test_clamping();
    // zero sizes act as one pixel
    set_geometry(0, 0, 0);
    send_random(3);
    // oversized output falls back to the smaller source side
    set_geometry(3, 2, 8191);
    send_random(12);
  endtask

  task automatic test_uneven_footprints();
    set_geometry(7, 5, 3);
    send_random(35);
  endtask

  task automatic test_ignored_index();
    set_geometry(4, 4, 2);
    send_random(6);
    write_reg(REG_UNUSED, CFG_W'($urandom));
    send_random(10);
  endtask

  task automatic test_widest_row();
    set_geometry(256, 256, 256);
    send_random(256);
  endtask

  task automatic test_longest_footprint();
    set_geometry(48, 1, 1);
    gapless = 1'b1;
    for (int i = 0; i < 48; i++) send_pixel(8'd255, 8'd255, 8'd255, i != 47);
    gapless = 1'b0;
  endtask

  task automatic test_backpressure();
    set_geometry(8, 8, 8);
    gapless = 1'b1;
    hold_go <= 1'b1;
    send_random(64);
    gapless = 1'b0;
    drain();
  endtask

  task automatic test_random(int target);
    int sent, w, h, n;
    sent = 0;
    while (sent < target) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      if ($urandom_range(3) == 0) write_reg(REG_SRC_WIDTH, CFG_W'(w));
      else set_geometry(w, h, $urandom_range(1, 14));
      w = width_eff();
      h = height_eff();
      gapless = ($urandom_range(3) == 0);
      n = w * h * $urandom_range(1, 3);
      if ($urandom_range(3) == 0) n += $urandom_range(0, w * h - 1);
      if (n > target - sent) n = target - sent;
      send_random(n);
      sent += n;
    end
    gapless = 1'b0;
  endtask

  initial begin
    frame_restart();
    burst_left = $urandom_range(1, 20);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_clamping();
    test_uneven_footprints();
    test_ignored_index();
    test_widest_row();
    test_longest_footprint();
    test_backpressure();
    test_random(100);
    while (texels_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: box_filter_image_downscale.f
sv/bfd_pkg.sv
sv/bfd_ctrl.sv
sv/bfd_dp.sv
sv/box_filter_image_downscale.sv
sim/tb.sv
